// ===== rtl/stsd_pkg.sv =====
// shared types and constants for the sphere triangle subdivider
`timescale 1ns / 1ps
package stsd_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = 16;
  localparam int CNT_W      = 15;
  localparam int SUM_W      = COORD_W + 1;
  localparam int LEN_W      = 2 * SUM_W;
  localparam int MUL_W      = LEN_W;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int M_W        = FRAC_BITS + 1;
  localparam int T_W        = FRAC_BITS + 2;
  localparam int BIT_W      = $clog2(FRAC_BITS + 1);
  localparam int RHS_SHIFT  = 2 * FRAC_BITS + 2;
  localparam int NUM_MIDS   = 9;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 112;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;

  localparam logic [0:0] REG_FIRST = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  // positions: [vertex a,b,c][component x,y,z]
  typedef logic [2:0][2:0][COORD_W-1:0] tri_pos_t;
  typedef logic [NUM_MIDS-1:0][COORD_W-1:0] mids_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LEN_MUL,
    SQ_LEN_ACC,
    SQ_ASQ_MUL,
    SQ_ASQ_TAKE,
    SQ_TSQ_MUL,
    SQ_TL_MUL,
    SQ_CMP
  } seq_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_CALC,
    TOP_EMIT
  } top_state_t;

endpackage

// ===== rtl/stsd_mul.sv =====
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
module stsd_mul
  import stsd_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a_i,
  input  logic [MUL_W-1:0]  op_b_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_r;

endmodule

// ===== rtl/stsd_seq.sv =====
// sequencer for edge sums, lengths and bitwise normalization search
`timescale 1ns / 1ps
module stsd_seq
  import stsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start_i,
  input  tri_pos_t pos_i,
  output logic     done_o,
  output mids_t    mids_o
);

  seq_state_t        state_r, state_nxt;
  logic [1:0]        edge_r, edge_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [M_W-1:0]    m_r, m_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PROD_W-1:0] rhs_r, rhs_nxt;
  mids_t             res_r, res_nxt;

  logic [1:0]        pv, qv;
  logic [SUM_W-1:0]  sum, mag;
  logic              neg;
  logic [M_W-1:0]    trial, m_fin;
  logic [T_W-1:0]    t_val;
  logic              fits;
  logic [3:0]        ridx;
  logic [COORD_W-1:0] m_ext;
  logic [MUL_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod;

  stsd_mul u_mul (
    .clk    (clk),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // edge endpoints: ab, bc, ca
  always_comb begin
    unique case (edge_r)
      2'd0:    begin pv = 2'd0; qv = 2'd1; end
      2'd1:    begin pv = 2'd1; qv = 2'd2; end
      2'd2:    begin pv = 2'd2; qv = 2'd0; end
      default: begin pv = 2'd0; qv = 2'd1; end
    endcase
  end

  assign sum   = {pos_i[pv][comp_r][COORD_W-1], pos_i[pv][comp_r]}
               + {pos_i[qv][comp_r][COORD_W-1], pos_i[qv][comp_r]};
  assign neg   = sum[SUM_W-1];
  assign mag   = neg ? (SUM_W'(0) - sum) : sum;
  assign trial = m_r | (M_W'(1) << bit_r);
  assign t_val = {trial, 1'b0} - T_W'(1);
  // a zero component, including a zero-length sum, stays zero
  assign fits  = (mag != '0) && (prod <= rhs_r)
               && (trial <= (M_W'(1) << FRAC_BITS));
  assign m_fin = fits ? trial : m_r;
  assign m_ext = COORD_W'(m_fin);
  assign ridx  = 4'(edge_r) * 4'd3 + 4'(comp_r);

  always_comb begin
    state_nxt = state_r;
    edge_nxt  = edge_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    m_nxt     = m_r;
    len_nxt   = len_r;
    rhs_nxt   = rhs_r;
    res_nxt   = res_r;
    op_a      = '0;
    op_b      = '0;
    done_o    = 1'b0;
    unique case (state_r)
      SQ_IDLE: begin
        if (start_i) begin
          edge_nxt  = 2'd0;
          comp_nxt  = 2'd0;
          len_nxt   = '0;
          state_nxt = SQ_LEN_MUL;
        end
      end
      SQ_LEN_MUL: begin
        op_a      = MUL_W'(mag);
        op_b      = MUL_W'(mag);
        state_nxt = SQ_LEN_ACC;
      end
      SQ_LEN_ACC: begin
        len_nxt = len_r + prod[LEN_W-1:0];
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = SQ_ASQ_MUL;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = SQ_LEN_MUL;
        end
      end
      SQ_ASQ_MUL: begin
        op_a      = MUL_W'(mag);
        op_b      = MUL_W'(mag);
        state_nxt = SQ_ASQ_TAKE;
      end
      SQ_ASQ_TAKE: begin
        rhs_nxt   = prod << RHS_SHIFT;
        m_nxt     = '0;
        bit_nxt   = BIT_W'(FRAC_BITS);
        state_nxt = SQ_TSQ_MUL;
      end
      SQ_TSQ_MUL: begin
        op_a      = MUL_W'(t_val);
        op_b      = MUL_W'(t_val);
        state_nxt = SQ_TL_MUL;
      end
      SQ_TL_MUL: begin
        op_a      = MUL_W'(prod[2*T_W-1:0]);
        op_b      = MUL_W'(len_r);
        state_nxt = SQ_CMP;
      end
      SQ_CMP: begin
        m_nxt = m_fin;
        if (bit_r == '0) begin
          res_nxt[ridx] = neg ? (COORD_W'(0) - m_ext) : m_ext;
          if (comp_r == 2'd2) begin
            comp_nxt = 2'd0;
            if (edge_r == 2'd2) begin
              done_o    = 1'b1;
              state_nxt = SQ_IDLE;
            end else begin
              edge_nxt  = edge_r + 2'd1;
              len_nxt   = '0;
              state_nxt = SQ_LEN_MUL;
            end
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = SQ_ASQ_MUL;
          end
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = SQ_TSQ_MUL;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    edge_r <= edge_nxt;
    comp_r <= comp_nxt;
    bit_r  <= bit_nxt;
    m_r    <= m_nxt;
    len_r  <= len_nxt;
    rhs_r  <= rhs_nxt;
    res_r  <= res_nxt;
  end

  assign mids_o = res_r;

endmodule

// ===== rtl/sphere_triangle_subdivider_unit.sv =====
// top level of the sphere triangle subdivider
`timescale 1ns / 1ps
// usage:
// one request on the in_ stream is one triangle: three corner indices and
// three positions in signed q1.14. for each triangle the block sends four
// requests on the out_ stream: the triangles (a,ab,ca), (b,bc,ab), (bc,c,ca)
// and (ab,bc,ca). the first three also carry a new normalized midpoint and
// its index (out_tuser[0] set); the fourth has out_tlast set, and
// out_tuser[1] set when it ends the pass of triangle_count triangles.
// all nine midpoint components go through one shared multiplier: per edge
// the squared length is summed over the components, then per component
// SQ_ASQ_MUL and SQ_ASQ_TAKE set up 15 search steps of SQ_TSQ_MUL, SQ_TL_MUL, SQ_CMP.
// a new triangle is accepted only after all four results of the last one are
// taken; in_tready is high only while the block is idle.
// a stalled result is held until taken; an apb register write changes its new indices.
// reset: first_new_vertex 12, triangle_count 20, new pass started.
// a register write over the apb port also starts a new pass.
module sphere_triangle_subdivider_unit
  import stsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // corner_a, corner_b, corner_c, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tri_first, tri_second, tri_third, vertex_index, vertex_x, vertex_y, vertex_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // vertex_valid, pass_done
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [APB_W-1:0]      cfg_pwdata,
  output logic [APB_W-1:0]      cfg_prdata,
  output logic                  cfg_pready
);

  top_state_t         state_r, state_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]   first_r, nv_r;
  logic [CNT_W-1:0]   count_r, tdone_r;
  logic [IDX_W-1:0]   ia_r, ib_r, ic_r;
  tri_pos_t           pos_r;
  logic               in_acc, out_acc, cfg_wr, seq_done, pass_end;
  mids_t              mids;
  logic [IDX_W-1:0]   iab, ibc, ica;
  logic [CNT_W-1:0]   tdone_inc;
  tri_pos_t           in_pos;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready  = (state_r == TOP_IDLE);
  assign out_tvalid = (state_r == TOP_EMIT);

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        in_pos[v][c] = in_tdata[3*IDX_W + COORD_W*(3*v + c) +: COORD_W];
      end
    end
  end

  stsd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .pos_i   (pos_r),
    .done_o  (seq_done),
    .mids_o  (mids)
  );

  assign iab       = nv_r;
  assign ibc       = nv_r + IDX_W'(1);
  assign ica       = nv_r + IDX_W'(2);
  assign tdone_inc = tdone_r + CNT_W'(1);
  assign pass_end  = (tdone_inc == count_r);

  always_comb begin
    out_tuser = 2'b00;
    out_tlast = 1'b0;
    unique case (k_r)
      2'd0: begin
        out_tdata = {mids[2], mids[1], mids[0], iab, ica, iab, ia_r};
        out_tuser = 2'b01;
      end
      2'd1: begin
        out_tdata = {mids[5], mids[4], mids[3], ibc, iab, ibc, ib_r};
        out_tuser = 2'b01;
      end
      2'd2: begin
        out_tdata = {mids[8], mids[7], mids[6], ica, ica, ic_r, ibc};
        out_tuser = 2'b01;
      end
      default: begin
        out_tdata = {(4*COORD_W)'(0), ica, ibc, iab};
        out_tuser = {pass_end, 1'b0};
        out_tlast = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      TOP_IDLE: if (in_acc) state_nxt = TOP_CALC;
      TOP_CALC: begin
        if (seq_done) begin
          state_nxt = TOP_EMIT;
          k_nxt     = 2'd0;
        end
      end
      TOP_EMIT: begin
        if (out_acc) begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) state_nxt = TOP_IDLE;
        end
      end
      default: state_nxt = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TOP_IDLE;
      k_r     <= 2'd0;
      first_r <= IDX_W'(12);
      count_r <= CNT_W'(20);
      nv_r    <= IDX_W'(12);
      tdone_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_FIRST: begin
            first_r <= cfg_pwdata[IDX_W-1:0];
            nv_r    <= cfg_pwdata[IDX_W-1:0];
          end
          REG_COUNT: begin
            count_r <= cfg_pwdata[CNT_W-1:0];
            nv_r    <= first_r;
          end
          default: ;
        endcase
        tdone_r <= '0;
      end else if (out_acc && k_r == 2'd3) begin
        if (pass_end) begin
          tdone_r <= '0;
          nv_r    <= first_r;
        end else begin
          tdone_r <= tdone_inc;
          nv_r    <= nv_r + IDX_W'(3);
        end
      end
    end
    if (in_acc) begin
      ia_r  <= in_tdata[IDX_W-1:0];
      ib_r  <= in_tdata[2*IDX_W-1:IDX_W];
      ic_r  <= in_tdata[3*IDX_W-1:2*IDX_W];
      pos_r <= in_pos;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FIRST: cfg_prdata = APB_W'(first_r);
      REG_COUNT: cfg_prdata = APB_W'(count_r);
      default:   cfg_prdata = '0;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at once");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> state_r == TOP_CALC)
    else $error("sequencer finished outside calc");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> k_r == 2'd0)
    else $error("results do not start with first triangle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && k_r == 2'd3 && !cfg_wr && pass_end) |=> tdone_r == '0)
    else $error("pass counter not cleared at pass end");

endmodule
